FILE: rtl/core/svf_pkg.sv
// ----------------------------------------------------------------------------
// svf_pkg
// Shared codes for the state variable filter: register indexes, output
// modes and sequencer states.
// ----------------------------------------------------------------------------
package svf_pkg;

	localparam int unsigned CFG_INDEX_WIDTH = 3;
	typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

	localparam cfg_index_t REG_COEF_A1     = 3'd0;
	localparam cfg_index_t REG_COEF_A2     = 3'd1;
	localparam cfg_index_t REG_COEF_A3     = 3'd2;
	localparam cfg_index_t REG_DAMPING     = 3'd3;
	localparam cfg_index_t REG_FILTER_MODE = 3'd4;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_LOWPASS  = 2'd0;
	localparam mode_t MODE_BANDPASS = 2'd1;
	localparam mode_t MODE_HIGHPASS = 2'd2;

	typedef logic [3:0] seq_state_t;
	localparam seq_state_t ST_IDLE = 4'd0;
	localparam seq_state_t ST_M1   = 4'd1;
	localparam seq_state_t ST_M2   = 4'd2;
	localparam seq_state_t ST_M3   = 4'd3;
	localparam seq_state_t ST_M4   = 4'd4;
	localparam seq_state_t ST_M5   = 4'd5;
	localparam seq_state_t ST_M6   = 4'd6;
	localparam seq_state_t ST_M7   = 4'd7;
	localparam seq_state_t ST_FIN  = 4'd8;

endpackage

FILE: rtl/core/state_variable_filter.sv
// ----------------------------------------------------------------------------
// state_variable_filter
// Trapezoidal state variable filter: lowpass, bandpass or highpass output
// from two saturating integrators, all products on one shared multiplier.
// Timing: an accepted item runs through states M1 to M7 and then FIN, where
//   the result is registered; FIN holds while the previous result still waits on out_ready.
// Items: a new item is taken only in IDLE, after the last one left FIN; five
//   products through the single multiplier plus its pipeline register and the final update set the pace.
// Reset: arst_n clears both integrators, the configuration registers, the
//   sequencer and out_valid; datapath registers are not reset.
// ----------------------------------------------------------------------------
module state_variable_filter
	import svf_pkg::*;
#(
	parameter int SAMPLE_WIDTH     = 24,
	parameter int COEF_FRAC_BITS   = 16,
	parameter int STATE_GUARD_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_we,
	input  cfg_index_t                       cfg_index,
	input  logic [COEF_FRAC_BITS+1:0]        cfg_data,
	// input channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]   sample_in,
	// output channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]   sample_out
);

	// state width, multiplier operands, accumulator and rounded widths
	localparam int STW  = SAMPLE_WIDTH + STATE_GUARD_BITS;
	localparam int V3W  = STW + 1;
	localparam int MAW  = STW + 4;             // holds z1, v3 and v1
	localparam int MBW  = COEF_FRAC_BITS + 3;  // coefficient plus sign bit
	localparam int PW   = MAW + MBW;
	localparam int ACCW = PW + 1;
	localparam int RW   = ACCW - COEF_FRAC_BITS;
	localparam int TW   = MAW + 2;             // 2*v - z
	localparam int YW   = RW + 2;              // x - kv - v2

	localparam logic signed [ACCW-1:0] RND_HALF =
		ACCW'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [TW-1:0] ST_HI =
		{{(TW-STW+1){1'b0}}, {(STW-1){1'b1}}};
	localparam logic signed [TW-1:0] ST_LO = ~ST_HI;
	localparam logic signed [YW-1:0] Y_HI =
		{{(YW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [YW-1:0] Y_LO = ~Y_HI;

	// configuration
	logic [COEF_FRAC_BITS:0]   coef_a1_q, coef_a2_q, coef_a3_q;
	logic [COEF_FRAC_BITS+1:0] damping_q;
	mode_t                     filter_mode_q;

	// integrators and working registers
	logic signed [STW-1:0]          z1_q, z2_q;
	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic signed [V3W-1:0]          v3_q;
	logic signed [MAW-1:0]          v1_q, v2_q;
	logic signed [RW-1:0]           kv_q;
	logic signed [PW-1:0]           prod_q;
	logic signed [ACCW-1:0]         acc_q;
	seq_state_t                     state_q;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;

	// shared multiplier operands
	logic signed [MAW-1:0] mul_a;
	logic signed [MBW-1:0] mul_b;

	logic                    in_acc, fin_go;
	logic signed [V3W-1:0]   v3_next;
	logic signed [ACCW-1:0]  prod_ext, acc_sum, rnd_sum;
	logic signed [RW-1:0]    rnd;
	logic signed [RW-1:0]    v2_sum;
	logic signed [TW-1:0]    t1, t2;
	logic signed [STW-1:0]   z1_next, z2_next;
	logic signed [YW-1:0]    y_raw;
	logic signed [SAMPLE_WIDTH-1:0] y_sat;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_acc     = in_valid && in_ready;
	assign fin_go     = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	assign v3_next = V3W'(sample_in) - V3W'(z2_q);

	// operand select per sequencer step
	always_comb begin
		mul_a = MAW'(z1_q);
		mul_b = MBW'($signed({1'b0, coef_a1_q}));
		case (state_q)
			ST_M1: begin
				mul_a = MAW'(z1_q);
				mul_b = MBW'($signed({1'b0, coef_a1_q}));
			end
			ST_M2: begin
				mul_a = MAW'(v3_q);
				mul_b = MBW'($signed({1'b0, coef_a2_q}));
			end
			ST_M3: begin
				mul_a = MAW'(z1_q);
				mul_b = MBW'($signed({1'b0, coef_a2_q}));
			end
			ST_M4: begin
				mul_a = MAW'(v3_q);
				mul_b = MBW'($signed({1'b0, coef_a3_q}));
			end
			ST_M5: begin
				mul_a = v1_q;
				mul_b = MBW'($signed({1'b0, damping_q}));
			end
			default: begin
				mul_a = MAW'(z1_q);
				mul_b = MBW'($signed({1'b0, coef_a1_q}));
			end
		endcase
	end

	// accumulate and round to nearest, ties up: add half LSB, floor shift
	assign prod_ext = ACCW'(prod_q);
	assign acc_sum  = acc_q + prod_ext;
	assign rnd_sum  = acc_q + RND_HALF;
	assign rnd      = rnd_sum[ACCW-1:COEF_FRAC_BITS];
	assign v2_sum   = RW'(z2_q) + rnd;

	// integrator update: 2*v - z, saturated to the state width
	assign t1 = $signed({v1_q[MAW-1], v1_q, 1'b0}) - TW'(z1_q);
	assign t2 = $signed({v2_q[MAW-1], v2_q, 1'b0}) - TW'(z2_q);

	always_comb begin
		if (t1 > ST_HI)
			z1_next = STW'(ST_HI);
		else if (t1 < ST_LO)
			z1_next = STW'(ST_LO);
		else
			z1_next = t1[STW-1:0];
		if (t2 > ST_HI)
			z2_next = STW'(ST_HI);
		else if (t2 < ST_LO)
			z2_next = STW'(ST_LO);
		else
			z2_next = t2[STW-1:0];
	end

	// output select; the unused mode gives zero
	always_comb begin
		case (filter_mode_q)
			MODE_LOWPASS:  y_raw = YW'(v2_q);
			MODE_BANDPASS: y_raw = YW'(kv_q);
			MODE_HIGHPASS: y_raw = YW'(x_q) - YW'(kv_q) - YW'(v2_q);
			default:       y_raw = '0;
		endcase
		if (y_raw > Y_HI)
			y_sat = SAMPLE_WIDTH'(Y_HI);
		else if (y_raw < Y_LO)
			y_sat = SAMPLE_WIDTH'(Y_LO);
		else
			y_sat = y_raw[SAMPLE_WIDTH-1:0];
	end

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a1_q     <= '0;
			coef_a2_q     <= '0;
			coef_a3_q     <= '0;
			damping_q     <= '0;
			filter_mode_q <= MODE_LOWPASS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COEF_A1:     coef_a1_q     <= cfg_data[COEF_FRAC_BITS:0];
				REG_COEF_A2:     coef_a2_q     <= cfg_data[COEF_FRAC_BITS:0];
				REG_COEF_A3:     coef_a3_q     <= cfg_data[COEF_FRAC_BITS:0];
				REG_DAMPING:     damping_q     <= cfg_data;
				REG_FILTER_MODE: filter_mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// sequencer, integrators and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			z1_q        <= '0;
			z2_q        <= '0;
		end else begin
			// a new result wins over the release of the old one
			if (fin_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_acc) state_q <= ST_M1;
				ST_M1:   state_q <= ST_M2;
				ST_M2:   state_q <= ST_M3;
				ST_M3:   state_q <= ST_M4;
				ST_M4:   state_q <= ST_M5;
				ST_M5:   state_q <= ST_M6;
				ST_M6:   state_q <= ST_M7;
				ST_M7:   state_q <= ST_FIN;
				ST_FIN: begin
					// hold here while the previous result is still unclaimed
					if (fin_go) begin
						z1_q    <= z1_next;
						z2_q    <= z2_next;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (in_acc) begin
			x_q  <= sample_in;
			v3_q <= v3_next;
		end
		case (state_q)
			ST_M2: acc_q <= prod_ext;          // a1*z1
			ST_M3: acc_q <= acc_sum;           // + a2*v3
			ST_M4: begin
				v1_q  <= rnd[MAW-1:0];
				acc_q <= prod_ext;             // a2*z1
			end
			ST_M5: acc_q <= acc_sum;           // + a3*v3
			ST_M6: begin
				v2_q  <= v2_sum[MAW-1:0];
				acc_q <= prod_ext;             // k*v1
			end
			ST_M7: kv_q <= rnd;
			default: ;
		endcase
		if (fin_go)
			sample_out_q <= y_sat;
	end

	// an accepted item starts the product sequence
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_M1)
		else $error("sequencer did not start on accepted item");

	// an unclaimed result is never overwritten
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_valid_q && !out_ready) |=> state_q == ST_FIN)
		else $error("result overwritten before it was taken");

	// a new result appears only from the final step
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("result valid raised outside final step");

	// no item is taken while the sequencer is busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_acc)
		else $error("item accepted while busy");

endmodule
